// ----- design/ffa_pkg.sv -----
`default_nettype none
package ffa_pkg;

  localparam int unsigned MaxBlocksDef = 64;
  localparam int unsigned AlignBitsDef = 4;
  localparam int unsigned AddrWidthDef = 32;

  localparam logic [31:0] HeapBaseRst   = 32'd0;
  localparam logic [31:0] HeapLengthRst = 32'd4194304;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOFIT    = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  localparam logic [1:0] CFG_HEAP_BASE   = 2'd0;
  localparam logic [1:0] CFG_HEAP_LENGTH = 2'd1;

  typedef struct packed {
    logic        kind;
    logic [31:0] req_size;
    logic [31:0] block_address;
  } ffa_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] granted_address;
    logic [31:0] granted_size;
    logic [31:0] bytes_in_use;
  } ffa_out_t;

  // one block descriptor as held in the table memory
  typedef struct packed {
    logic        used;
    logic [31:0] start;
    logic [31:0] size;
  } ffa_blk_t;

endpackage
`default_nettype wire

// ----- design/ffa_ram.sv -----
`default_nettype none
module ffa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- design/first_fit_heap_allocator_top.sv -----
// First-fit heap allocator: block table of MAX_BLOCKS descriptors in one RAM with a registered read.
// Sequence: alloc scans for the first fit, checks room, shifts the later entries up on a split,
//   then writes the descriptors; free scans for the used block, writes the merged free block and
//   shifts the later entries down; a miss ends the scan at the last entry.
// Throughput: one request at a time; the result register may hold the next accept back.
// Reset (synchronous, rst_n low) and heap_base/heap_length writes made while idle rebuild one free block.
`default_nettype none
module first_fit_heap_allocator_top
  import ffa_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS = MaxBlocksDef,
  parameter int unsigned ALIGN_BITS = AlignBitsDef,
  parameter int unsigned ADDR_WIDTH = AddrWidthDef
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire ffa_in_t     in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output ffa_out_t         out_data,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_wdata
);

  localparam int unsigned IW = $clog2(MAX_BLOCKS);
  localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);
  localparam logic [33:0] MASK = 34'((64'd1 << ALIGN_BITS) - 64'd1);
  localparam logic [33:0] LIM  = (ADDR_WIDTH >= 32) ? 34'h1_0000_0000
                                                    : 34'(64'd1 << ADDR_WIDTH);
  localparam logic [CW:0] MAXC = (CW+1)'(MAX_BLOCKS);

  typedef enum logic [7:0] {
    S_INIT  = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_SCAN  = 8'b0000_0100,
    S_ACHK  = 8'b0000_1000,
    S_FNEXT = 8'b0001_0000,
    S_SHIFT = 8'b0010_0000,
    S_AWR   = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  state_t         state_r, state_nxt;
  logic [31:0]    base_r, len_r;
  logic [CW-1:0]  count_r, count_nxt;
  logic [31:0]    used_r, used_nxt;

  // request being served
  logic           kind_r;
  logic [31:0]    req_r, addr_r;

  // scan pipeline
  logic [IW-1:0]  ptr_r, ptr_nxt;
  logic [IW-1:0]  idx_r, idx_nxt;
  logic           dv_r, dv_nxt;
  logic [IW-1:0]  hit_r, hit_nxt;
  ffa_blk_t       prev_r, prev_nxt;
  ffa_blk_t       cur_r, cur_nxt;
  logic [33:0]    a_r, a_nxt, e_r, e_nxt;

  // shift engine
  logic [IW-1:0]  sh_rd_r, sh_rd_nxt;
  logic [CW-1:0]  sh_cnt_r, sh_cnt_nxt;
  logic           sh_wdv_r, sh_wdv_nxt;
  logic [IW-1:0]  sh_wa_r, sh_wa_nxt;
  logic           sh_up_r, sh_up_nxt;
  logic [IW-1:0]  sh_off_r, sh_off_nxt;

  // descriptor write sequence for alloc: 0 head, 1 used, 2 tail
  logic [1:0]     wj_r, wj_nxt, wj_end_r, wj_end_nxt;
  logic [IW-1:0]  wa_r, wa_nxt;

  // result
  logic [1:0]     st_r, st_nxt;
  logic [31:0]    ga_r, ga_nxt, gs_r, gs_nxt;
  logic           out_valid_r, out_valid_nxt;
  ffa_out_t       out_data_r, out_data_nxt;

  // memory port
  logic           mem_we;
  logic [IW-1:0]  mem_wa, mem_ra;
  ffa_blk_t       mem_wd, rd;

  ffa_ram #(
    .WIDTH ($bits(ffa_blk_t)),
    .DEPTH (MAX_BLOCKS)
  ) u_tbl (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_wa),
    .wdata (mem_wd),
    .raddr (mem_ra),
    .rdata (rd)
  );

  // initial block length, clipped to the address space
  logic [33:0] base34, init_len;
  always_comb begin
    base34 = {2'b00, base_r};
    if (base34 >= LIM) begin
      init_len = '0;
    end else if ({2'b00, len_r} > LIM - base34) begin
      init_len = LIM - base34;
    end else begin
      init_len = {2'b00, len_r};
    end
  end

  // first-fit test (alloc) or address match (free) on the descriptor coming out of the memory
  logic [33:0] s34, e34, a34;
  logic        fit, match, hit, last;
  always_comb begin
    s34   = {2'b00, rd.start};
    e34   = s34 + {2'b00, rd.size};
    a34   = (s34 + MASK) & ~MASK;
    fit   = !rd.used && (a34 + {2'b00, req_r} <= e34) && (a34 < LIM);
    match = rd.used && (rd.start == addr_r);
    hit   = dv_r && ((kind_r == KIND_ALLOC) ? fit : match);
    last  = (CW'(idx_r) + CW'(1)) == count_r;
  end

  // alloc split decisions
  logic       head, tail;
  logic [1:0] need;
  always_comb begin
    head = a_r > {2'b00, cur_r.start};
    tail = {2'b00, req_r} < (e_r - a_r);
    need = {1'b0, head} + {1'b0, tail};
  end

  // free merge decisions (rd holds the next entry in S_FNEXT)
  logic       has_next, nf, pf;
  logic [1:0] rm;
  always_comb begin
    has_next = (CW'(hit_r) + CW'(1)) < count_r;
    nf       = has_next && !rd.used;
    pf       = (hit_r != '0) && !prev_r.used;
    rm       = {1'b0, pf} + {1'b0, nf};
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    used_nxt      = used_r;
    ptr_nxt       = ptr_r;
    idx_nxt       = idx_r;
    dv_nxt        = 1'b0;
    hit_nxt       = hit_r;
    prev_nxt      = prev_r;
    cur_nxt       = cur_r;
    a_nxt         = a_r;
    e_nxt         = e_r;
    sh_rd_nxt     = sh_rd_r;
    sh_cnt_nxt    = sh_cnt_r;
    sh_wdv_nxt    = 1'b0;
    sh_wa_nxt     = sh_wa_r;
    sh_up_nxt     = sh_up_r;
    sh_off_nxt    = sh_off_r;
    wj_nxt        = wj_r;
    wj_end_nxt    = wj_end_r;
    wa_nxt        = wa_r;
    st_nxt        = st_r;
    ga_nxt        = ga_r;
    gs_nxt        = gs_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_wa        = '0;
    mem_wd        = '0;
    mem_ra        = ptr_r;

    // drop the result beat once taken
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_INIT: begin
        mem_we     = 1'b1;
        mem_wa     = '0;
        mem_wd     = '{used: 1'b0, start: base_r, size: init_len[31:0]};
        count_nxt  = CW'(1);
        used_nxt   = '0;
        state_nxt  = S_IDLE;
      end
      S_IDLE: begin
        if (cfg_we && (cfg_index == CFG_HEAP_BASE || cfg_index == CFG_HEAP_LENGTH)) begin
          state_nxt = S_INIT;
        end else if (in_valid) begin
          ptr_nxt   = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        // issue one read per cycle, check the entry read last cycle
        ptr_nxt = ptr_r + IW'(1);
        idx_nxt = ptr_r;
        dv_nxt  = 1'b1;
        if (dv_r) begin
          if (hit) begin
            dv_nxt  = 1'b0;
            hit_nxt = idx_r;
            cur_nxt = rd;
            a_nxt   = a34;
            e_nxt   = e34;
            state_nxt = (kind_r == KIND_ALLOC) ? S_ACHK : S_FNEXT;
          end else if (last) begin
            dv_nxt    = 1'b0;
            st_nxt    = (kind_r == KIND_ALLOC) ? ST_NOFIT : ST_NOTFOUND;
            ga_nxt    = '0;
            gs_nxt    = '0;
            state_nxt = S_DONE;
          end else begin
            prev_nxt = rd;
          end
        end
      end
      S_ACHK: begin
        if ({1'b0, count_r} + (CW+1)'(need) > MAXC) begin
          st_nxt    = ST_FULL;
          ga_nxt    = '0;
          gs_nxt    = '0;
          state_nxt = S_DONE;
        end else begin
          count_nxt  = count_r + CW'(need);
          used_nxt   = used_r + req_r;
          st_nxt     = ST_OK;
          ga_nxt     = a_r[31:0];
          gs_nxt     = req_r;
          sh_up_nxt  = 1'b1;
          sh_off_nxt = IW'(need);
          sh_rd_nxt  = IW'(count_r - CW'(1));
          sh_cnt_nxt = (need == 2'd0) ? '0 : (count_r - CW'(hit_r) - CW'(1));
          wj_nxt     = head ? 2'd0 : 2'd1;
          wj_end_nxt = tail ? 2'd2 : 2'd1;
          wa_nxt     = hit_r;
          state_nxt  = S_SHIFT;
        end
      end
      S_FNEXT: begin
        // write the merged free block, then close the gap
        mem_we = 1'b1;
        mem_wa = pf ? (hit_r - IW'(1)) : hit_r;
        mem_wd.used  = 1'b0;
        mem_wd.start = pf ? prev_r.start : cur_r.start;
        mem_wd.size  = (pf ? prev_r.size : 32'd0) + cur_r.size + (nf ? rd.size : 32'd0);
        count_nxt  = count_r - CW'(rm);
        used_nxt   = used_r - cur_r.size;
        st_nxt     = ST_OK;
        ga_nxt     = addr_r;
        gs_nxt     = cur_r.size;
        sh_up_nxt  = 1'b0;
        sh_off_nxt = IW'(rm);
        sh_rd_nxt  = hit_r + IW'(1) + IW'(nf);
        sh_cnt_nxt = (rm == 2'd0) ? '0 : (count_r - CW'(hit_r) - CW'(1) - CW'(nf));
        state_nxt  = S_SHIFT;
      end
      S_SHIFT: begin
        mem_ra = sh_rd_r;
        if (sh_cnt_r != '0) begin
          sh_cnt_nxt = sh_cnt_r - CW'(1);
          sh_wdv_nxt = 1'b1;
          sh_wa_nxt  = sh_up_r ? (sh_rd_r + sh_off_r) : (sh_rd_r - sh_off_r);
          sh_rd_nxt  = sh_up_r ? (sh_rd_r - IW'(1)) : (sh_rd_r + IW'(1));
        end else begin
          state_nxt = (kind_r == KIND_ALLOC) ? S_AWR : S_DONE;
        end
        if (sh_wdv_r) begin
          mem_we = 1'b1;
          mem_wa = sh_wa_r;
          mem_wd = rd;
        end
      end
      S_AWR: begin
        mem_we = 1'b1;
        mem_wa = wa_r;
        case (wj_r)
          2'd0: mem_wd = '{used: 1'b0, start: cur_r.start,
                           size: 32'(a_r - {2'b00, cur_r.start})};
          2'd1: mem_wd = '{used: 1'b1, start: a_r[31:0], size: req_r};
          default: mem_wd = '{used: 1'b0, start: 32'(a_r + {2'b00, req_r}),
                              size: 32'(e_r - a_r - {2'b00, req_r})};
        endcase
        wa_nxt = wa_r + IW'(1);
        wj_nxt = wj_r + 2'd1;
        if (wj_r == wj_end_r) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{status: st_r, granted_address: ga_r,
                            granted_size: gs_r, bytes_in_use: used_r};
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      base_r      <= HeapBaseRst;
      len_r       <= HeapLengthRst;
      count_r     <= CW'(1);
      used_r      <= '0;
      dv_r        <= 1'b0;
      sh_wdv_r    <= 1'b0;
      sh_cnt_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      used_r      <= used_nxt;
      dv_r        <= dv_nxt;
      sh_wdv_r    <= sh_wdv_nxt;
      sh_cnt_r    <= sh_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we && cfg_index == CFG_HEAP_BASE) begin
        base_r <= cfg_wdata;
      end
      if (cfg_we && cfg_index == CFG_HEAP_LENGTH) begin
        len_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      kind_r <= in_data.kind;
      req_r  <= in_data.req_size;
      addr_r <= in_data.block_address;
    end
    ptr_r      <= ptr_nxt;
    idx_r      <= idx_nxt;
    hit_r      <= hit_nxt;
    prev_r     <= prev_nxt;
    cur_r      <= cur_nxt;
    a_r        <= a_nxt;
    e_r        <= e_nxt;
    sh_rd_r    <= sh_rd_nxt;
    sh_wa_r    <= sh_wa_nxt;
    sh_up_r    <= sh_up_nxt;
    sh_off_r   <= sh_off_nxt;
    wj_r       <= wj_nxt;
    wj_end_r   <= wj_end_nxt;
    wa_r       <= wa_nxt;
    st_r       <= st_nxt;
    ga_r       <= ga_nxt;
    gs_r       <= gs_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
`default_nettype wire
